### hw/rtl/ptc_pkg.sv
// shared constants, types and codes for the perceptron train/classify block
package ptc_pkg;

  localparam int MAX_DIM    = 32;
  localparam int MIN_DIM    = 2;
  localparam int ADDR_W     = $clog2(MAX_DIM);
  localparam int DIM_W      = 6;
  localparam int CNT_W      = ((ADDR_W > DIM_W) ? ADDR_W : DIM_W) + 1;
  localparam int FEAT_W     = 16;
  localparam int WEIGHT_W   = 32;
  localparam int PROD_W     = FEAT_W + WEIGHT_W;
  localparam int SUM_W      = 48;
  localparam int BAND_W     = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam int DIM_RESET  = 2;
  localparam int BAND_RESET = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIMENSION = 1'b0,
    REG_ZERO_BAND = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_DECIDE,
    ST_UPD,
    ST_UPD_END
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;  // element transaction taken this cycle
    logic acc;     // add registered product into the running sum
    logic push;    // load result register, clear sum and index
    logic walk;    // issue one read of the weight update walk
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;         // element just taken closes the vector
    logic out_free;     // result register can take a new result
    logic need_update;  // finished training vector was mispredicted
    logic walk_last;    // walk is issuing its final element
  } ctl_status_t;

endpackage

### hw/rtl/ptc_ram.sv
// generic single write port, single read port ram with registered read
module ptc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/ptc_ctrl.sv
// controller state machine: element sequencing, result hand-off, weight update walk
module ptc_ctrl import ptc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  ctl_status_t status,
  output ctl_cmd_t    ctl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.accept = 1'b1;
          state_next = ST_ACC;
        end
      end
      ST_ACC: begin
        ctl.acc    = 1'b1;
        state_next = status.last ? ST_DECIDE : ST_IDLE;
      end
      ST_DECIDE: begin
        if (status.out_free) begin
          ctl.push   = 1'b1;
          state_next = status.need_update ? ST_UPD : ST_IDLE;
        end
      end
      ST_UPD: begin
        ctl.walk = 1'b1;
        if (status.walk_last) begin
          state_next = ST_UPD_END;
        end
      end
      ST_UPD_END: begin
        // last write-back retires, weight of element zero is fetched
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/ptc_dp.sv
// datapath: config registers, buffers, multiply-accumulate, decision and weight update
module ptc_dp import ptc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  ctl_cmd_t              ctl,
  output ctl_status_t           status,
  input  logic                  cmd,
  input  logic signed [FEAT_W-1:0] feature_value,
  input  logic                  label_positive,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  tag_positive,
  output logic                  was_training,
  output logic                  weights_updated,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic signed [WEIGHT_W-1:0] W_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
  localparam logic signed [WEIGHT_W-1:0] W_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};

  logic [DIM_W-1:0]  dim;
  logic [BAND_W-1:0] zero_band;

  logic [ADDR_W-1:0] idx, idx_next;
  logic              last_q;
  logic              is_test;
  logic              label;
  logic signed [SUM_W-1:0]  sum;
  logic signed [PROD_W-1:0] prod;

  logic [ADDR_W-1:0] walk_end;
  logic [ADDR_W-1:0] uc;
  logic              wb_valid;
  logic [ADDR_W-1:0] wb_addr;

  logic [MAX_DIM-1:0] wvalid;
  logic               w_ok;
  logic [ADDR_W-1:0]  rd_addr;
  logic [WEIGHT_W-1:0] w_rdata;
  logic [FEAT_W-1:0]   f_rdata;
  logic signed [WEIGHT_W-1:0] w_cur;
  logic signed [WEIGHT_W-1:0] w_new;
  logic signed [WEIGHT_W:0]   w_ext, f_ext, w_sum;
  logic signed [SUM_W:0]      sum_add;
  logic signed [SUM_W-1:0]    sum_sat;
  logic signed [PROD_W-1:0]   prod_calc;

  logic [CNT_W-1:0] dim_ext, eff_dim, idx_plus;
  logic pred;

  // config transactions
  always_ff @(posedge clk) begin
    if (rst) begin
      dim       <= DIM_W'(DIM_RESET);
      zero_band <= BAND_W'(BAND_RESET);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DIMENSION: dim       <= cfg_data[DIM_W-1:0];
        REG_ZERO_BAND: zero_band <= cfg_data[BAND_W-1:0];
        default: ;
      endcase
    end
  end

  // effective dimension, clamped to the supported range
  always_comb begin
    dim_ext = CNT_W'(dim);
    if (dim_ext < CNT_W'(MIN_DIM)) begin
      eff_dim = CNT_W'(MIN_DIM);
    end else if (dim_ext > CNT_W'(MAX_DIM)) begin
      eff_dim = CNT_W'(MAX_DIM);
    end else begin
      eff_dim = dim_ext;
    end
    idx_plus = CNT_W'(idx) + CNT_W'(1);
  end

  // read address tracks the index being loaded so the weight is ready in idle
  always_comb begin
    idx_next = idx;
    if (ctl.push) begin
      idx_next = '0;
    end else if (ctl.acc && !last_q) begin
      idx_next = idx + 1'b1;
    end
    if (rst) begin
      idx_next = '0;
    end
    rd_addr = ctl.walk ? uc : idx_next;
  end

  assign w_cur     = w_ok ? $signed(w_rdata) : '0;
  assign prod_calc = feature_value * w_cur;

  // saturating accumulate
  always_comb begin
    sum_add = {sum[SUM_W-1], sum} + {prod[PROD_W-1], prod};
    if (sum_add[SUM_W] != sum_add[SUM_W-1]) begin
      sum_sat = sum_add[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_add[SUM_W-1:0];
    end
  end

  assign pred = !sum[SUM_W-1] && (sum != '0) &&
                (sum >= $signed({{(SUM_W-BAND_W){1'b0}}, zero_band}));

  // saturating weight update from the buffered feature
  always_comb begin
    w_ext = {w_cur[WEIGHT_W-1], w_cur};
    f_ext = {{(WEIGHT_W+1-FEAT_W){f_rdata[FEAT_W-1]}}, f_rdata};
    w_sum = label ? (w_ext + f_ext) : (w_ext - f_ext);
    if (w_sum[WEIGHT_W] != w_sum[WEIGHT_W-1]) begin
      w_new = w_sum[WEIGHT_W] ? W_MIN : W_MAX;
    end else begin
      w_new = w_sum[WEIGHT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      sum       <= '0;
      last_q    <= 1'b0;
      wb_valid  <= 1'b0;
      w_ok      <= 1'b0;
      wvalid    <= '0;
      out_valid <= 1'b0;
    end else begin
      idx      <= idx_next;
      w_ok     <= wvalid[rd_addr];
      wb_valid <= ctl.walk;
      if (ctl.accept) begin
        last_q <= idx_plus >= eff_dim;
      end
      if (ctl.acc) begin
        sum <= sum_sat;
      end else if (ctl.push) begin
        sum <= '0;
      end
      if (wb_valid) begin
        wvalid[wb_addr] <= 1'b1;
      end
      if (ctl.push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    wb_addr <= uc;
    if (ctl.accept) begin
      prod    <= prod_calc;
      is_test <= cmd;
      label   <= label_positive;
    end
    if (ctl.push) begin
      tag_positive    <= pred;
      was_training    <= !is_test;
      weights_updated <= !is_test && (pred != label);
      walk_end        <= idx;
      uc              <= '0;
    end else if (ctl.walk) begin
      uc <= uc + 1'b1;
    end
  end

  assign status.last        = last_q;
  assign status.out_free    = !out_valid || out_ready;
  assign status.need_update = !is_test && (pred != label);
  assign status.walk_last   = uc == walk_end;

  ptc_ram #(.WIDTH(FEAT_W), .DEPTH(MAX_DIM)) u_vec_buf (
    .clk   (clk),
    .we    (ctl.accept),
    .waddr (idx),
    .wdata (feature_value),
    .raddr (uc),
    .rdata (f_rdata)
  );

  ptc_ram #(.WIDTH(WEIGHT_W), .DEPTH(MAX_DIM)) u_weights (
    .clk   (clk),
    .we    (wb_valid),
    .waddr (wb_addr),
    .wdata (w_new),
    .raddr (rd_addr),
    .rdata (w_rdata)
  );

`ifndef NO_ASSERTIONS
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    ctl.push |-> (!out_valid || out_ready))
    else $error("result pushed over an untaken result");

  a_wb_range: assert property (@(posedge clk) disable iff (rst)
    wb_valid |-> (wb_addr <= walk_end))
    else $error("weight write-back beyond received elements");

  a_no_accept_in_walk: assert property (@(posedge clk) disable iff (rst)
    ctl.accept |-> !wb_valid)
    else $error("element taken while weight write-back pending");

  a_push_clears: assert property (@(posedge clk) disable iff (rst)
    ctl.push |=> (idx == '0) && (sum == '0))
    else $error("sum or index not cleared after result");
`endif

endmodule

### hw/rtl/perceptron_train_classify.sv
// top level of the online perceptron train/classify block
// Usage:
//   Feature elements arrive one per transaction on the input channel (in_valid/in_ready)
//   with cmd (0 train, 1 test), feature_value (Q8.8) and label_positive; cmd and label
//   count only on the last element of a vector. The vector length is the dimension
//   register clamped to 2..32. One result per vector leaves on the output channel
//   (out_valid/out_ready): tag_positive, was_training, weights_updated.
//   Config transactions (cfg_valid/cfg_ready, always ready) write register 0
//   (dimension) or 1 (zero band); the user must write them only while the block is idle (not enforced by the block).
// Timing:
//   each element is accepted, then accumulated into the saturating sum in a separate step;
//   the weight for the next element is prefetched from the weight ram during accumulate.
//   After the last element is accumulated, the decide step loads the result register.
//   A mispredicted training vector then walks the vector buffer at one weight per
//   cycle, and an end step retires the last write-back before the next element is taken.
//   A pending untaken result does not block new elements; only the next result
//   waits in the decide step until the output register is free.
// Reset:
//   rst clears the weights through per-entry valid bits (no clearing pass),
//   zeroes the sum and element index, and sets dimension 2 and zero band 1.
module perceptron_train_classify import ptc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     cmd,
  input  logic signed [FEAT_W-1:0] feature_value,
  input  logic                     label_positive,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     tag_positive,
  output logic                     was_training,
  output logic                     weights_updated,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  ctl_cmd_t    ctl;
  ctl_status_t status;

  assign cfg_ready = 1'b1;

  ptc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .ctl      (ctl)
  );

  ptc_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .ctl             (ctl),
    .status          (status),
    .cmd             (cmd),
    .feature_value   (feature_value),
    .label_positive  (label_positive),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .tag_positive    (tag_positive),
    .was_training    (was_training),
    .weights_updated (weights_updated),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

endmodule
